// File: src/rpa_pkg.sv
// Package for the register pool allocator: command codes, widths, and the
// search token and command types. No dependencies.
package rpa_pkg;
	localparam int NumRegsDefault = 16;
	localparam int IdxW = 4;
	localparam int DataW = 16;
	localparam int AddrRegs = 16;

	typedef enum logic [2:0] {
		OP_ALLOC    = 3'd0,
		OP_ALLOC_AT = 3'd1,
		OP_ACQUIRE  = 3'd2,
		OP_RELEASE  = 3'd3,
		OP_MOVE     = 3'd4,
		OP_FIND     = 3'd5,
		OP_FURTHEST = 3'd6,
		OP_EXPIRE   = 3'd7
	} op_t;

	// Search token handed from cell to cell along the chain.
	typedef struct packed {
		logic             free_seen;
		logic             hit;
		logic [5:0]       reg_sel;
		logic [DataW-1:0] vid;
		logic [DataW-1:0] use_idx;
	} chain_t;

	// Command held for the duration of one pass.
	typedef struct packed {
		op_t              op;
		logic [5:0]       idx;
		logic [DataW-1:0] vid;
		logic [DataW-1:0] use_idx;
		logic [DataW-1:0] lim;
	} cmd_t;
endpackage

// File: src/rpa_cell.sv
// One register of the pool: busy bit, entry, and one link of the search chain.
// Depends on rpa_pkg.
module rpa_cell #(
	parameter int Pos = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            commit,
	input  rpa_pkg::cmd_t   cmd,
	input  logic [5:0]      dst,
	input  logic            dst_ok,
	input  logic            src_valid,
	input  logic [15:0]     src_vid,
	input  logic [15:0]     src_use,
	input  rpa_pkg::chain_t chain_in,
	output rpa_pkg::chain_t chain_out,
	output logic            valid_o,
	output logic [15:0]     vid_o,
	output logic [15:0]     use_o,
	output logic            expired_o
);
	import rpa_pkg::*;

	localparam logic [5:0] Me = 6'(Pos);

	logic        busy_q;
	logic        valid_q;
	logic [15:0] vid_q;
	logic [15:0] use_q;
	chain_t      nxt;

	assign valid_o = valid_q;
	assign vid_o = vid_q;
	assign use_o = use_q;
	assign expired_o = valid_q && (use_q <= cmd.lim);

	// Fold this register into the token.
	always_comb begin
		nxt = chain_in;
		case (cmd.op)
			OP_ALLOC, OP_MOVE: begin
				if (!busy_q && !chain_in.free_seen) begin
					nxt.free_seen = 1'b1;
					nxt.reg_sel = Me;
				end
			end
			OP_FIND: begin
				if (!chain_in.hit && valid_q && vid_q == cmd.vid) begin
					nxt.hit = 1'b1;
					nxt.reg_sel = Me;
					nxt.vid = vid_q;
					nxt.use_idx = use_q;
				end
			end
			OP_FURTHEST: begin
				if (valid_q && (!chain_in.hit || use_q > chain_in.use_idx)) begin
					nxt.hit = 1'b1;
					nxt.reg_sel = Me;
					nxt.vid = vid_q;
					nxt.use_idx = use_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_out <= '0;
		end else if (step) begin
			chain_out <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			valid_q <= 1'b0;
			vid_q <= '0;
			use_q <= '0;
		end else if (commit) begin
			case (cmd.op)
				OP_ALLOC: begin
					if (dst_ok && dst == Me) begin
						busy_q <= 1'b1;
						valid_q <= 1'b1;
						vid_q <= cmd.vid;
						use_q <= cmd.use_idx;
					end
				end
				OP_ALLOC_AT: begin
					if (cmd.idx == Me) begin
						busy_q <= 1'b1;
						valid_q <= 1'b1;
						vid_q <= cmd.vid;
						use_q <= cmd.use_idx;
					end
				end
				OP_ACQUIRE: begin
					if (cmd.idx == Me) busy_q <= 1'b1;
				end
				OP_RELEASE: begin
					if (cmd.idx == Me) begin
						busy_q <= 1'b0;
						valid_q <= 1'b0;
					end
				end
				OP_MOVE: begin
					if (dst_ok && dst == Me) begin
						busy_q <= 1'b1;
						valid_q <= src_valid;
						vid_q <= src_vid;
						use_q <= src_use;
					end else if (dst_ok && cmd.idx == Me) begin
						busy_q <= 1'b0;
						valid_q <= 1'b0;
					end
				end
				OP_EXPIRE: begin
					if (expired_o) begin
						busy_q <= 1'b0;
						valid_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// File: src/register_pool_allocator.sv
// Top level of the register pool allocator: command channel, chain of
// rpa_cell registers, and the result register. Depends on rpa_pkg, rpa_cell.
//
// Use: a command word enters on in_valid/in_stall with opcode, reg_index,
// value_id, use_index and expire_index. Each command yields exactly one
// result word on out_valid/out_stall (ok, result_reg, result_value_id,
// result_use_index, released_mask).
// The pool is a row of NUM_REGS cells. A search token (lowest free, first
// match, greatest last-use) walks the row one cell per cycle; a command
// takes NUM_REGS steps of the chain from acceptance, then a commit that
// updates the cells and loads the output register together. No new command
// is accepted during the walk or commit; the next one is accepted on the
// cycle after commit, even while the previous result is still held in the
// output register.
// Reset clears every busy bit and entry and empties the output register.
// When the receiver stalls, the result holds; a new command may finish its
// walk but waits at commit until the output register is free.
module register_pool_allocator #(
	parameter int NUM_REGS = rpa_pkg::NumRegsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [3:0]  reg_index,
	input  logic [15:0] value_id,
	input  logic [15:0] use_index,
	input  logic [15:0] expire_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [3:0]  result_reg,
	output logic [15:0] result_value_id,
	output logic [15:0] result_use_index,
	output logic [15:0] released_mask
);
	import rpa_pkg::*;

	localparam int CntW = $clog2(NUM_REGS + 1);
	localparam int SelW = $clog2(NUM_REGS);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_COMMIT} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	logic [CntW-1:0] cnt_q;
	logic            step;
	logic            commit;
	logic            in_pool;
	logic            out_free;
	chain_t          chain [NUM_REGS+1];
	logic            cell_valid [NUM_REGS];
	logic [15:0]     cell_vid [NUM_REGS];
	logic [15:0]     cell_use [NUM_REGS];
	logic [NUM_REGS-1:0] expired;
	logic [SelW-1:0] src_sel;
	logic [15:0]     mask16;
	chain_t          tail;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign step = (state_q == ST_WALK);
	assign commit = (state_q == ST_COMMIT) && out_free;
	assign in_pool = {3'b000, cmd_q.idx[3:0]} < 7'(NUM_REGS);
	assign src_sel = SelW'(cmd_q.idx);
	// Token enters the head of the row empty.
	assign chain[0] = '0;
	assign tail = chain[NUM_REGS];

	// Only one token ever walks: each cell registers its output, and after
	// NUM_REGS steps the tail holds the full answer.
	for (genvar g = 0; g < NUM_REGS; g++) begin : g_cell
		rpa_cell #(.Pos(g)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (step),
			.commit    (commit && (in_pool || cmd_q.op == OP_ALLOC
			            || cmd_q.op == OP_EXPIRE)),
			.cmd       (cmd_q),
			.dst       (tail.reg_sel),
			.dst_ok    (tail.free_seen),
			.src_valid (cell_valid[src_sel]),
			.src_vid   (cell_vid[src_sel]),
			.src_use   (cell_use[src_sel]),
			.chain_in  (chain[g]),
			.chain_out (chain[g+1]),
			.valid_o   (cell_valid[g]),
			.vid_o     (cell_vid[g]),
			.use_o     (cell_use[g]),
			.expired_o (expired[g])
		);
	end

	// Report only the first sixteen registers in the mask.
	always_comb begin
		mask16 = '0;
		for (int i = 0; i < NUM_REGS && i < AddrRegs; i++) mask16[i] = expired[i];
	end

	// Sequence: accept, walk the row, then commit and load the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			cmd_q <= '0;
			out_valid <= 1'b0;
			ok <= 1'b0;
			result_reg <= '0;
			result_value_id <= '0;
			result_use_index <= '0;
			released_mask <= '0;
		end else begin
			if (commit) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q.op <= op_t'(opcode);
						cmd_q.idx <= {2'b00, reg_index};
						cmd_q.vid <= value_id;
						cmd_q.use_idx <= use_index;
						cmd_q.lim <= expire_index;
						cnt_q <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(NUM_REGS - 1)) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (out_free) begin
						ok <= 1'b0;
						result_reg <= '0;
						result_value_id <= '0;
						result_use_index <= '0;
						released_mask <= '0;
						case (cmd_q.op)
							OP_ALLOC: begin
								ok <= tail.free_seen;
								if (tail.free_seen) result_reg <= tail.reg_sel[3:0];
							end
							OP_ALLOC_AT, OP_ACQUIRE, OP_RELEASE: begin
								ok <= in_pool;
								if (in_pool) result_reg <= cmd_q.idx[3:0];
							end
							OP_MOVE: begin
								ok <= in_pool && tail.free_seen;
								if (in_pool && tail.free_seen)
									result_reg <= tail.reg_sel[3:0];
							end
							OP_FIND, OP_FURTHEST: begin
								ok <= tail.hit;
								if (tail.hit) begin
									result_reg <= tail.reg_sel[3:0];
									result_value_id <= tail.vid;
									result_use_index <= tail.use_idx;
								end
							end
							OP_EXPIRE: begin
								ok <= |expired;
								released_mask <= mask16;
							end
							default: ;
						endcase
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_commit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid) else $error("commit did not load result");
	a_walk_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && cnt_q == CntW'(NUM_REGS - 1)) |=> state_q == ST_COMMIT)
		else $error("walk length wrong");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(result_reg))
		else $error("result dropped under stall");
endmodule

// File: verif/register_pool_allocator_tb.sv
// Self-checking testbench for register_pool_allocator: directed table, then
// random command words checked against a behavioral pool model.
// Depends on rpa_pkg and the register_pool_allocator RTL.
module register_pool_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rpa_pkg::*;

	localparam int NREGS = 16;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		logic        ok;
		logic [3:0]  rreg;
		logic [15:0] rvid;
		logic [15:0] ruse;
		logic [15:0] mask;
	} pool_result_t;

	typedef struct {
		op_t         op;
		logic [3:0]  idx;
		logic [15:0] vid;
		logic [15:0] use_idx;
		logic [15:0] lim;
		bit          has_fixed;
		pool_result_t fixed;
	} cmd_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = '0;
	logic [3:0]  reg_index = '0;
	logic [15:0] value_id = '0;
	logic [15:0] use_index = '0;
	logic [15:0] expire_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        ok;
	logic [3:0]  result_reg;
	logic [15:0] result_value_id;
	logic [15:0] result_use_index;
	logic [15:0] released_mask;

	register_pool_allocator #(.NUM_REGS(NREGS)) dut (.*);

	always #10 clk = ~clk;

	// Model of the pool state, advanced once per accepted command word
	logic [15:0] mdl_busy;
	logic        mdl_valid [NREGS];
	logic [15:0] mdl_vid [NREGS];
	logic [15:0] mdl_use [NREGS];

	pool_result_t pending_results[$];
	int mismatches = 0;
	int results_seen = 0;
	bit sender_done = 1'b0;
	bit long_hold = 1'b0;
	int op_count [8];

	// Compute the result of one command and update the model state.
	function automatic pool_result_t pool_apply(cmd_row_t c);
		pool_result_t r;
		int dst;
		bit v;
		logic [15:0] cv, cu;
		r = '0;
		dst = -1;
		for (int i = 0; i < NREGS; i++)
			if (dst < 0 && !mdl_busy[i])
				dst = i;
		case (c.op)
			OP_ALLOC: if (dst >= 0) begin
				mdl_busy[dst] = 1'b1;
				mdl_valid[dst] = 1'b1;
				mdl_vid[dst] = c.vid;
				mdl_use[dst] = c.use_idx;
				r.ok = 1'b1;
				r.rreg = dst[3:0];
			end
			OP_ALLOC_AT: begin
				mdl_busy[c.idx] = 1'b1;
				mdl_valid[c.idx] = 1'b1;
				mdl_vid[c.idx] = c.vid;
				mdl_use[c.idx] = c.use_idx;
				r.ok = 1'b1;
				r.rreg = c.idx;
			end
			OP_ACQUIRE: begin
				mdl_busy[c.idx] = 1'b1;
				r.ok = 1'b1;
				r.rreg = c.idx;
			end
			OP_RELEASE: begin
				mdl_busy[c.idx] = 1'b0;
				mdl_valid[c.idx] = 1'b0;
				r.ok = 1'b1;
				r.rreg = c.idx;
			end
			OP_MOVE: if (dst >= 0) begin
				v = mdl_valid[c.idx];
				cv = mdl_vid[c.idx];
				cu = mdl_use[c.idx];
				mdl_busy[c.idx] = 1'b0;
				mdl_valid[c.idx] = 1'b0;
				mdl_busy[dst] = 1'b1;
				mdl_valid[dst] = v;
				mdl_vid[dst] = cv;
				mdl_use[dst] = cu;
				r.ok = 1'b1;
				r.rreg = dst[3:0];
			end
			OP_FIND: for (int i = NREGS - 1; i >= 0; i--)
				if (mdl_valid[i] && mdl_vid[i] == c.vid) begin
					r.ok = 1'b1;
					r.rreg = i[3:0];
					r.rvid = mdl_vid[i];
					r.ruse = mdl_use[i];
				end
			OP_FURTHEST: for (int i = 0; i < NREGS; i++)
				if (mdl_valid[i] && (!r.ok || mdl_use[i] > r.ruse)) begin
					r.ok = 1'b1;
					r.rreg = i[3:0];
					r.rvid = mdl_vid[i];
					r.ruse = mdl_use[i];
				end
			default: for (int i = 0; i < NREGS; i++)
				if (mdl_valid[i] && mdl_use[i] <= c.lim) begin
					mdl_busy[i] = 1'b0;
					mdl_valid[i] = 1'b0;
					r.mask[i] = 1'b1;
					r.ok = 1'b1;
				end
		endcase
		return r;
	endfunction

	function automatic cmd_row_t mk(op_t op, int idx, int vid, int use_idx, int lim);
		cmd_row_t c;
		c.op = op;
		c.idx = idx[3:0];
		c.vid = vid[15:0];
		c.use_idx = use_idx[15:0];
		c.lim = lim[15:0];
		c.has_fixed = 1'b0;
		c.fixed = '0;
		return c;
	endfunction

	function automatic cmd_row_t mk_fixed(op_t op, int idx, int vid, int use_idx,
			int lim, pool_result_t fx);
		cmd_row_t c;
		c = mk(op, idx, vid, use_idx, lim);
		c.has_fixed = 1'b1;
		c.fixed = fx;
		return c;
	endfunction

	// Random command; biased toward allocs and keys that hit live entries.
	function automatic cmd_row_t rand_cmd();
		cmd_row_t c;
		int k;
		c = mk(op_t'($urandom_range(0, 7)), $urandom_range(0, 15), $urandom,
			$urandom, $urandom);
		k = $urandom_range(0, 15);
		if ($urandom_range(0, 9) < 3)
			c.op = ($urandom_range(0, 1) != 0) ? OP_ALLOC : OP_ALLOC_AT;
		if ($urandom_range(0, 3) != 0)
			c.vid = 16'($urandom_range(0, 15));
		if (c.op == OP_FIND && mdl_valid[k] && $urandom_range(0, 1) != 0)
			c.vid = mdl_vid[k];
		if ($urandom_range(0, 3) == 0)
			c.use_idx = 16'($urandom_range(0, 3));
		if (c.op == OP_EXPIRE && $urandom_range(0, 2) != 0)
			c.lim = 16'($urandom_range(0, 16383));
		return c;
	endfunction

	// Drive one command word and hold it until accepted.
	task automatic send_word(cmd_row_t c);
		pool_result_t r;
		int gap;
		gap = $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= c.op;
		reg_index <= c.idx;
		value_id <= c.vid;
		use_index <= c.use_idx;
		expire_index <= c.lim;
		do @(posedge clk); while (in_stall);
		r = pool_apply(c);
		// A typed-in result must agree with the model as well
		if (c.has_fixed && r != c.fixed) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row disagrees: op %s table %h model %h",
					c.op.name(), c.fixed, r);
		end
		pending_results.push_back(c.has_fixed ? c.fixed : r);
		op_count[c.op]++;
	endtask

	// Receiver: random stall per word, one long hold-off to fill the block.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (200) @(posedge clk);
				long_hold = 1'b0;
			end
			hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		pool_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {ok, result_reg, result_value_id, result_use_index, released_mask};
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp ok=%b reg=%0d vid=%h use=%h mask=%h,",
							" got ok=%b reg=%0d vid=%h use=%h mask=%h"},
							want.ok, want.rreg, want.rvid, want.ruse, want.mask,
							got.ok, got.rreg, got.rvid, got.ruse, got.mask);
				end
			end
		end
	end

	// Main sequence: reset, directed table, random words, drain.
	initial begin
		cmd_row_t tbl[$];
		int wait_cnt;
		mdl_busy = '0;
		for (int i = 0; i < NREGS; i++) begin
			mdl_valid[i] = 1'b0;
			mdl_vid[i] = '0;
			mdl_use[i] = '0;
		end
		// Empty pool: searches miss, expire releases nothing
		tbl.push_back(mk_fixed(OP_FIND, 0, 0, 0, 0, '0));
		tbl.push_back(mk_fixed(OP_FURTHEST, 0, 0, 0, 0, '0));
		tbl.push_back(mk_fixed(OP_EXPIRE, 0, 0, 0, 16'hFFFF, '0));
		tbl.push_back(mk_fixed(OP_ALLOC, 0, 16'hFFFF, 16'hFFFF, 0,
			{1'b1, 4'd0, 32'd0, 16'd0}));
		tbl.push_back(mk_fixed(OP_ALLOC_AT, 15, 0, 0, 0, {1'b1, 4'd15, 48'd0}));
		tbl.push_back(mk(OP_FIND, 0, 16'hFFFF, 0, 0));
		tbl.push_back(mk(OP_FURTHEST, 0, 0, 0, 0));
		// Move from an unused register lands busy with no entry
		tbl.push_back(mk(OP_MOVE, 7, 0, 0, 0));
		// Move when the source is itself the lowest free register
		tbl.push_back(mk(OP_MOVE, 2, 0, 0, 0));
		tbl.push_back(mk(OP_ACQUIRE, 9, 0, 0, 0));
		tbl.push_back(mk(OP_RELEASE, 0, 0, 0, 0));
		tbl.push_back(mk(OP_ALLOC, 0, 16'h1234, 16'hFFFF, 0));
		tbl.push_back(mk(OP_FURTHEST, 0, 0, 0, 0));
		for (int i = 0; i < 14; i++)
			tbl.push_back(mk(OP_ALLOC, 0, 16'hAAAA, 16'h5555, 0));
		tbl.push_back(mk(OP_MOVE, 15, 0, 0, 0));
		tbl.push_back(mk(OP_EXPIRE, 0, 0, 0, 16'hFFFE));
		tbl.push_back(mk(OP_EXPIRE, 0, 0, 0, 16'hFFFF));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (tbl[i])
			send_word(tbl[i]);
		for (int n = 0; n < 1020; n++) begin
			if (n == 400)
				long_hold = 1'b1;
			send_word(rand_cmd());
		end
		in_valid <= 1'b0;
		sender_done = 1'b1;
		wait_cnt = 0;
		while (pending_results.size() != 0 && wait_cnt < 20000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (40) @(posedge clk);
		$display("Ran %0d command words, %0d results; ops alloc..expire: %0d %0d %0d %0d %0d %0d %0d %0d",
			tbl.size() + 1020, results_seen, op_count[0], op_count[1], op_count[2],
			op_count[3], op_count[4], op_count[5], op_count[6], op_count[7]);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				pending_results.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(LIMIT_CYCLES * 20);
		$display("timeout");
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
